// ===== rtl/rfbt_pkg.sv =====
package rfbt_pkg;

    // sizing defaults
    localparam int DEF_QUEUE_DEPTH  = 8;
    localparam int DEF_REMOTE_SLOTS = 4;
    localparam int BLINDS           = 16;
    localparam int BLIND_W          = 4;

    // config port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_HALF     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE      = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_GAP     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING       = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PAIRS   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LATER_PAIRS   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNTER_START = 4'd7;

    localparam logic [15:0] RST_SYNC_HALF     = 16'd295;
    localparam logic [15:0] RST_HALF_BIT      = 16'd640;
    localparam logic [15:0] RST_PREAMBLE      = 16'd6800;
    localparam logic [15:0] RST_FRAME_GAP     = 16'd25000;
    localparam logic [19:0] RST_SPACING       = 20'd500000;
    localparam logic [9:0]  RST_FIRST_PAIRS   = 10'd434;
    localparam logic [9:0]  RST_LATER_PAIRS   = 10'd59;
    localparam logic [15:0] RST_COUNTER_START = 16'h0410;

    // frame constants
    localparam logic [7:0] HDR_BYTE = 8'h81;
    localparam logic [7:0] SUM_SEED = 8'h2B;

    // waveform phases
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_SYNC_HI  = 3'd1;
    localparam logic [2:0] PH_SYNC_LO  = 3'd2;
    localparam logic [2:0] PH_PREAMBLE = 3'd3;
    localparam logic [2:0] PH_LEAD_LO  = 3'd4;
    localparam logic [2:0] PH_BIT_A    = 3'd5;
    localparam logic [2:0] PH_BIT_B    = 3'd6;
    localparam logic [2:0] PH_GAP      = 3'd7;

    typedef struct packed {
        logic        command;
        logic [23:0] remote_id;
        logic [3:0]  blind_id;
        logic [7:0]  blind_command;
        logic [7:0]  repeat_count;
    } t_in_item;

    typedef struct packed {
        logic       pin_level;
        logic       busy_res;
        logic       queue_full;
        logic [3:0] pending;
    } t_out_item;

    typedef struct packed {
        logic [23:0] remote;
        logic [3:0]  blind;
        logic [7:0]  cmd;
        logic [7:0]  reps;
    } t_queued;

    typedef struct packed {
        logic [2:0]  phase;
        logic [15:0] dur;
        logic [9:0]  idx;
        logic [7:0]  frames;
        logic        first;
        logic        fin;
    } t_wave;

endpackage

// ===== rtl/rf_blind_command_transmitter.sv =====
// Blind remote transmitter. Each input item is either a tick (one microsecond of
// pin waveform) or a command to queue; both kinds are accepted one per clock and
// each returns one result item through an output register, so a result shows in the
// cycle after its item is accepted; the block stops taking items while that result is
// stalled. Sustained rate: one item per cycle; only a stalled output register
// stops intake. A queued command starts on a tick once the block is idle and the
// spacing after the previous command has run out; its rolling counter comes out of
// a per-remote counter memory in a read-modify-write pipeline that runs
// beside the waveform sequencer (the counter bytes are not on air for at least 33
// ticks after start, so the pipeline never shows). No clearing pass after reset:
// a remote slot marks its 16 counters stale when it is allocated and stale
// counters read as the start value latched at allocation.
module rf_blind_command_transmitter #(
    parameter int QUEUE_DEPTH  = rfbt_pkg::DEF_QUEUE_DEPTH,
    parameter int REMOTE_SLOTS = rfbt_pkg::DEF_REMOTE_SLOTS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // item in
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  rfbt_pkg::t_in_item                 i_in_item,
    // result out
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output rfbt_pkg::t_out_item                o_out_item,
    // config writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rfbt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rfbt_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import rfbt_pkg::*;

    localparam int QW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW        = $clog2(QUEUE_DEPTH + 1);
    localparam int SW        = (REMOTE_SLOTS > 1) ? $clog2(REMOTE_SLOTS) : 1;
    localparam int CTR_DEPTH = REMOTE_SLOTS * BLINDS;
    localparam int AW        = SW + BLIND_W;

    // ------------------------------------------------------------------
    // config registers
    // ------------------------------------------------------------------
    logic [15:0] r_sync_half, r_half_bit, r_preamble, r_gap, r_ctr_start;
    logic [19:0] r_spacing_cfg;
    logic [9:0]  r_first_pairs, r_later_pairs;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_half   <= RST_SYNC_HALF;
            r_half_bit    <= RST_HALF_BIT;
            r_preamble    <= RST_PREAMBLE;
            r_gap         <= RST_FRAME_GAP;
            r_spacing_cfg <= RST_SPACING;
            r_first_pairs <= RST_FIRST_PAIRS;
            r_later_pairs <= RST_LATER_PAIRS;
            r_ctr_start   <= RST_COUNTER_START;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SYNC_HALF:     r_sync_half   <= i_cfg_data[15:0];
                CFG_HALF_BIT:      r_half_bit    <= i_cfg_data[15:0];
                CFG_PREAMBLE:      r_preamble    <= i_cfg_data[15:0];
                CFG_FRAME_GAP:     r_gap         <= i_cfg_data[15:0];
                CFG_SPACING:       r_spacing_cfg <= i_cfg_data;
                CFG_FIRST_PAIRS:   r_first_pairs <= i_cfg_data[9:0];
                CFG_LATER_PAIRS:   r_later_pairs <= i_cfg_data[9:0];
                CFG_COUNTER_START: r_ctr_start   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshake: output register parts the two sides
    // ------------------------------------------------------------------
    logic r_out_valid;
    t_out_item r_out_item;
    logic in_acc, tick, enq;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign tick        = in_acc && !i_in_item.command;
    assign enq         = in_acc && i_in_item.command;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // ------------------------------------------------------------------
    // state registers
    // ------------------------------------------------------------------
    logic [QW-1:0] r_head;
    logic [CW-1:0] r_count;
    t_queued       r_fifo [QUEUE_DEPTH];
    t_queued       r_head_item;      // prefetched copy of the head entry

    logic [2:0]  r_phase;
    logic [15:0] r_dur;
    logic [9:0]  r_idx;
    logic [7:0]  r_frames;
    logic        r_first;
    logic [19:0] r_spacing;
    logic [63:0] r_frame;

    logic [REMOTE_SLOTS-1:0] r_tag_valid;
    logic [23:0]             r_tag        [REMOTE_SLOTS];
    logic [15:0]             r_slot_start [REMOTE_SLOTS];
    logic [SW-1:0]           r_repl;

    logic [15:0]          r_ctr_mem [CTR_DEPTH];
    logic [CTR_DEPTH-1:0] r_live;    // counter written since slot allocation
    logic [15:0]          r_ctr_q;   // registered memory read
    logic                 r_s2_valid;
    logic [AW-1:0]        r_s2_addr;
    logic [7:0]           r_s2_sum;
    logic                 r_wb_valid;
    logic [AW-1:0]        r_wb_addr;
    logic [15:0]          r_wb_data;

    // ------------------------------------------------------------------
    // queue
    // ------------------------------------------------------------------
    logic          start, fifo_full, wr_en;
    logic [QW:0]   tail_sum;
    logic [QW-1:0] wr_addr, head_inc, n_head;
    logic [CW-1:0] n_count;
    t_queued       new_q;

    assign new_q     = '{remote: i_in_item.remote_id, blind: i_in_item.blind_id,
                         cmd: i_in_item.blind_command, reps: i_in_item.repeat_count};
    assign fifo_full = (r_count == CW'(QUEUE_DEPTH));
    assign wr_en     = enq && !fifo_full;
    assign start     = tick && (r_phase == PH_IDLE) && (r_spacing == '0) && (r_count != '0);

    always_comb begin
        tail_sum = {1'b0, r_head} + (QW+1)'(r_count);
        if (tail_sum >= (QW+1)'(QUEUE_DEPTH)) begin
            tail_sum = tail_sum - (QW+1)'(QUEUE_DEPTH);
        end
        wr_addr  = tail_sum[QW-1:0];
        head_inc = (r_head == QW'(QUEUE_DEPTH - 1)) ? '0 : r_head + QW'(1);
        n_head   = start ? head_inc : r_head;
        n_count  = r_count + CW'(wr_en) - CW'(start);
    end

    // ------------------------------------------------------------------
    // remote slot lookup (stage 1 of the counter pipeline)
    // ------------------------------------------------------------------
    logic          hit, has_free;
    logic [SW-1:0] hit_slot, free_slot, slot_sel, repl_inc;
    logic          alloc;
    logic [AW-1:0] ctr_addr;
    logic [7:0]    part_sum;

    always_comb begin
        hit       = 1'b0;
        hit_slot  = '0;
        has_free  = 1'b0;
        free_slot = '0;
        for (int s = 0; s < REMOTE_SLOTS; s++) begin
            if (!hit && r_tag_valid[s] && (r_tag[s] == r_head_item.remote)) begin
                hit      = 1'b1;
                hit_slot = SW'(s);
            end
            if (!has_free && !r_tag_valid[s]) begin
                has_free  = 1'b1;
                free_slot = SW'(s);
            end
        end
        slot_sel = hit ? hit_slot : (has_free ? free_slot : r_repl);
        alloc    = start && !hit;
        repl_inc = (r_repl == SW'(REMOTE_SLOTS - 1)) ? '0 : r_repl + SW'(1);
        ctr_addr = {slot_sel, r_head_item.blind};
        part_sum = SUM_SEED + r_head_item.cmd + {r_head_item.remote[19:16], r_head_item.blind}
                 + r_head_item.remote[15:8] + r_head_item.remote[7:0];
    end

    // stage 2: stale entries read the slot's start value, a write from the
    // previous cycle is forwarded past the memory
    logic [15:0] ctr_cur;
    logic [7:0]  ck_sum;

    always_comb begin
        if (!r_live[r_s2_addr]) begin
            ctr_cur = r_slot_start[r_s2_addr[AW-1:BLIND_W]];
        end else if (r_wb_valid && (r_wb_addr == r_s2_addr)) begin
            ctr_cur = r_wb_data;
        end else begin
            ctr_cur = r_ctr_q;
        end
        ck_sum = r_s2_sum + ctr_cur[15:8] + ctr_cur[7:0];
    end

    // ------------------------------------------------------------------
    // waveform sequencer; zero-length elements are jumped over directly
    // ------------------------------------------------------------------
    function automatic t_wave finish_w();
        t_wave w;
        w       = '0;
        w.phase = PH_IDLE;
        w.fin   = 1'b1;
        return w;
    endfunction

    function automatic t_wave enter_frame(input logic first_f, input logic [7:0] frames);
        t_wave w;
        logic [9:0] pairs;
        pairs    = first_f ? r_first_pairs : r_later_pairs;
        w        = '0;
        w.frames = frames;
        w.first  = first_f;
        if ((pairs != '0) && (r_sync_half != '0)) begin
            w.phase = PH_SYNC_HI;
            w.dur   = r_sync_half;
        end else if (r_preamble != '0) begin
            w.phase = PH_PREAMBLE;
            w.dur   = r_preamble;
        end else if (r_half_bit != '0) begin
            w.phase = PH_LEAD_LO;
            w.dur   = r_half_bit;
        end else if (r_gap != '0) begin
            w.phase = PH_GAP;
            w.dur   = r_gap;
        end else if (first_f && (frames > 8'd1) && (r_later_pairs != '0)
                     && (r_sync_half != '0)) begin
            // empty first frame, later frames carry only sync pairs
            w.phase  = PH_SYNC_HI;
            w.dur    = r_sync_half;
            w.frames = frames - 8'd1;
            w.first  = 1'b0;
        end else begin
            w = finish_w();
        end
        return w;
    endfunction

    function automatic t_wave frame_end(input t_wave w);
        logic [7:0] left;
        left = w.frames - 8'd1;
        return (left != '0) ? enter_frame(1'b0, left) : finish_w();
    endfunction

    function automatic t_wave to_gap(input t_wave w);
        t_wave n;
        n = w;
        if (r_gap != '0) begin
            n.phase = PH_GAP;
            n.dur   = r_gap;
            return n;
        end
        return frame_end(w);
    endfunction

    function automatic t_wave after_preamble(input t_wave w);
        t_wave n;
        n = w;
        if (r_half_bit != '0) begin
            n.phase = PH_LEAD_LO;
            n.dur   = r_half_bit;
            return n;
        end
        return to_gap(w);
    endfunction

    function automatic t_wave after_sync(input t_wave w);
        t_wave n;
        n = w;
        if (r_preamble != '0) begin
            n.phase = PH_PREAMBLE;
            n.dur   = r_preamble;
            return n;
        end
        return after_preamble(w);
    endfunction

    function automatic t_wave advance(input t_wave w);
        t_wave n;
        logic [9:0] pairs;
        pairs = w.first ? r_first_pairs : r_later_pairs;
        n     = w;
        unique case (w.phase)
            PH_SYNC_HI: begin
                n.phase = PH_SYNC_LO;
                n.dur   = r_sync_half;
            end
            PH_SYNC_LO: begin
                if (({1'b0, w.idx} + 11'd1) < {1'b0, pairs}) begin
                    n.phase = PH_SYNC_HI;
                    n.dur   = r_sync_half;
                    n.idx   = w.idx + 10'd1;
                end else begin
                    n = after_sync(w);
                end
            end
            PH_PREAMBLE: n = after_preamble(w);
            PH_LEAD_LO: begin
                n.phase = PH_BIT_A;
                n.dur   = r_half_bit;
                n.idx   = '0;
            end
            PH_BIT_A: begin
                n.phase = PH_BIT_B;
                n.dur   = r_half_bit;
            end
            PH_BIT_B: begin
                if (w.idx < 10'd63) begin
                    n.phase = PH_BIT_A;
                    n.dur   = r_half_bit;
                    n.idx   = w.idx + 10'd1;
                end else begin
                    n = to_gap(w);
                end
            end
            PH_GAP:  n = frame_end(w);
            default: n = finish_w();
        endcase
        return n;
    endfunction

    function automatic logic level_of(input logic [2:0] ph, input logic [9:0] idx);
        logic b;
        b = r_frame[~idx[5:0]];
        unique case (ph) inside
            PH_SYNC_HI, PH_PREAMBLE: return 1'b1;
            PH_BIT_A:                return ~b;
            PH_BIT_B:                return b;
            default:                 return 1'b0;
        endcase
    endfunction

    t_wave cur, nxt;
    logic  tick_level, tick_busy;

    always_comb begin
        cur = '{phase: r_phase, dur: r_dur, idx: r_idx, frames: r_frames,
                first: r_first, fin: 1'b0};
        if (start) begin
            cur = (r_head_item.reps == '0) ? finish_w()
                                           : enter_frame(1'b1, r_head_item.reps);
        end
        nxt        = cur;
        tick_level = 1'b0;
        tick_busy  = 1'b0;
        if (tick && (cur.phase != PH_IDLE)) begin
            tick_level = level_of(cur.phase, cur.idx);
            tick_busy  = 1'b1;
            if (cur.dur == 16'd1) begin
                nxt = advance(cur);
            end else begin
                nxt.dur = cur.dur - 16'd1;
            end
        end
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_head      <= '0;
            r_count     <= '0;
            r_phase     <= PH_IDLE;
            r_dur       <= '0;
            r_idx       <= '0;
            r_frames    <= '0;
            r_first     <= 1'b0;
            r_spacing   <= '0;
            r_tag_valid <= '0;
            r_repl      <= '0;
            r_s2_valid  <= 1'b0;
            r_wb_valid  <= 1'b0;
        end else begin
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            r_head     <= n_head;
            r_count    <= n_count;
            r_s2_valid <= start;
            r_wb_valid <= r_s2_valid;
            if (tick) begin
                r_phase  <= nxt.phase;
                r_dur    <= nxt.dur;
                r_idx    <= nxt.idx;
                r_frames <= nxt.frames;
                r_first  <= nxt.first;
                if (nxt.fin) begin
                    r_spacing <= r_spacing_cfg;
                end else if ((r_phase == PH_IDLE) && (r_spacing != '0)) begin
                    r_spacing <= r_spacing - 20'd1;
                end
            end
            if (alloc) begin
                r_tag_valid[slot_sel] <= 1'b1;
                if (!has_free) begin
                    r_repl <= repl_inc;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // payload, memories and the counter pipeline
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_item.queue_full <= enq && fifo_full;
            r_out_item.pending    <= 4'(n_count);
            if (enq) begin
                r_out_item.pin_level <= level_of(r_phase, r_idx);
                r_out_item.busy_res  <= (r_phase != PH_IDLE);
            end else begin
                r_out_item.pin_level <= tick_level;
                r_out_item.busy_res  <= tick_busy;
            end
        end

        if (wr_en) begin
            r_fifo[wr_addr] <= new_q;
        end
        r_head_item <= (wr_en && (wr_addr == n_head)) ? new_q : r_fifo[n_head];

        if (alloc) begin
            r_tag[slot_sel]        <= r_head_item.remote;
            r_slot_start[slot_sel] <= r_ctr_start;
        end

        r_ctr_q <= r_ctr_mem[ctr_addr];
        if (start) begin
            r_s2_addr      <= ctr_addr;
            r_s2_sum       <= part_sum;
            r_frame[63:48] <= {HDR_BYTE, r_head_item.cmd};
            r_frame[31:8]  <= {r_head_item.remote[19:16], r_head_item.blind,
                               r_head_item.remote[15:0]};
        end

        if (r_s2_valid) begin
            r_ctr_mem[r_s2_addr] <= ctr_cur + 16'd1;
            r_live[r_s2_addr]    <= 1'b1;
            r_frame[47:32]       <= ctr_cur;
            r_frame[7:0]         <= ck_sum;
        end
        r_wb_addr <= r_s2_addr;
        r_wb_data <= ctr_cur + 16'd1;

        // a new remote makes its whole counter row stale; wins over the write-back
        if (alloc) begin
            for (int b = 0; b < BLINDS; b++) begin
                r_live[{slot_sel, BLIND_W'(b)}] <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/rfbt_chk.sv =====
module rfbt_chk #(
    parameter int QUEUE_DEPTH = rfbt_pkg::DEF_QUEUE_DEPTH
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input rfbt_pkg::t_out_item  o_out_item
);
    import rfbt_pkg::*;

    // result held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // intake only backs up behind a stalled result
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

    // pin is low whenever nothing is on air
    a_idle_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.busy_res |-> !o_out_item.pin_level)
        else $error("pin high while idle");

    // a dropped item means the queue is exactly full
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.queue_full |-> o_out_item.pending == 4'(QUEUE_DEPTH))
        else $error("drop reported with queue not full");

    a_pending_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (QUEUE_DEPTH > 15) || (o_out_item.pending <= 4'(QUEUE_DEPTH)))
        else $error("pending beyond queue depth");

endmodule

bind rf_blind_command_transmitter rfbt_chk #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_rfbt_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_item (o_out_item)
);
